// ===== rtl/core/ftfp_pkg.sv =====
// Shared types and constants of the fixed-timestep frame pacer.
package ftfp_pkg;

	localparam int TIME_BITS    = 48;
	localparam int CNT_BITS     = 32;
	localparam int PERIOD_BITS  = 24;
	localparam int ALPHA_FRAC   = 16;
	localparam int ALPHA_BITS   = ALPHA_FRAC + 1;
	localparam int MODE_BITS    = 2;
	localparam int Q_DEPTH      = 2;
	localparam int Q_PTR_BITS   = $clog2(Q_DEPTH);
	localparam int Q_CNT_BITS   = $clog2(Q_DEPTH + 1);
	localparam int DIV_STEPS    = TIME_BITS;
	localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

	typedef logic [TIME_BITS-1:0]   time_t;
	typedef logic [CNT_BITS-1:0]    cnt_t;
	typedef logic [PERIOD_BITS-1:0] period_t;
	typedef logic [ALPHA_BITS-1:0]  alpha_t;

	localparam period_t SIM_PERIOD_TICKS     = 24'd16667;
	localparam period_t PRESENT_PERIOD_RESET = 24'd16667;
	localparam period_t PERIOD_ONE           = 24'd1;
	localparam time_t   TIME_MAX             = {TIME_BITS{1'b1}};
	localparam cnt_t    CNT_MAX              = {CNT_BITS{1'b1}};
	localparam alpha_t  ALPHA_ONE            = alpha_t'(1) << ALPHA_FRAC;

	// Rounded-up reciprocal of the simulation period. For a numerator x below the
	// period, (x * ALPHA_RECIP) >> RECIP_SHIFT equals floor((x << ALPHA_FRAC) / period).
	localparam int ALPHA_L      = $clog2(int'(SIM_PERIOD_TICKS));
	localparam int ALPHA_X_BITS = (ALPHA_L < 1) ? 1 : ALPHA_L;
	localparam int RECIP_SHIFT  = 2 * ALPHA_L;
	localparam int RECIP_BITS   = ALPHA_FRAC + ALPHA_L + 2;
	localparam int PROD_BITS    = ALPHA_X_BITS + RECIP_BITS;
	localparam logic [RECIP_BITS-1:0] ALPHA_RECIP = RECIP_BITS'(
		((128'd1 << (ALPHA_FRAC + RECIP_SHIFT)) + 128'(SIM_PERIOD_TICKS) - 128'd1)
		/ 128'(SIM_PERIOD_TICKS));

	// Input modes as they arrive on the port.
	localparam logic [MODE_BITS-1:0] MODE_RESTART      = 2'd0;
	localparam logic [MODE_BITS-1:0] MODE_OBSERVE      = 2'd1;
	localparam logic [MODE_BITS-1:0] MODE_SIM_DONE     = 2'd2;
	localparam logic [MODE_BITS-1:0] MODE_PRESENT_DONE = 2'd3;

	typedef enum logic [1:0] {
		CMD_RESTART,
		CMD_OBSERVE,
		CMD_SIM_DONE,
		CMD_PRESENT_DONE
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		time_t     now;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic    start;
		time_t   dividend;
		period_t divisor;
	} div_req_t;

	typedef struct packed {
		logic    done;
		time_t   quotient;
		period_t remainder;
	} div_rsp_t;

endpackage

// ===== rtl/core/ftfp_queue.sv =====
// Two-entry command queue between the front and the back of the frame pacer.
module ftfp_queue import ftfp_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  cmd_t    push_data,
	input  logic    pop,
	output cmd_t    pop_data,
	output q_stat_t stat
);

	cmd_t                  entry_q [Q_DEPTH];
	logic [Q_PTR_BITS-1:0] wr_ptr_q;
	logic [Q_PTR_BITS-1:0] rd_ptr_q;
	logic [Q_CNT_BITS-1:0] count_q;

	function automatic logic [Q_PTR_BITS-1:0] ptr_inc(input logic [Q_PTR_BITS-1:0] p);
		return (p == Q_PTR_BITS'(Q_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign stat.full  = (count_q == Q_CNT_BITS'(Q_DEPTH));
	assign stat.empty = (count_q == '0);
	assign pop_data   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ===== rtl/core/ftfp_front.sv =====
// Front end: input handshake and translation of the mode into a command.
module ftfp_front import ftfp_pkg::*; (
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [MODE_BITS-1:0] mode,
	input  time_t                now,
	input  q_stat_t              q_stat,
	output logic                 push,
	output cmd_t                 push_data
);

	assign in_ready      = !q_stat.full;
	assign push          = in_valid && in_ready;
	assign push_data.now = now;

	always_comb begin
		unique case (mode)
			MODE_RESTART:      push_data.kind = CMD_RESTART;
			MODE_OBSERVE:      push_data.kind = CMD_OBSERVE;
			MODE_SIM_DONE:     push_data.kind = CMD_SIM_DONE;
			MODE_PRESENT_DONE: push_data.kind = CMD_PRESENT_DONE;
			default:           push_data.kind = CMD_OBSERVE;
		endcase
	end

endmodule

// ===== rtl/core/ftfp_div.sv =====
// Radix-2 restoring divider for the overdue-period count, one quotient bit per cycle.
module ftfp_div import ftfp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                    busy_q;
	logic                    done_q;
	logic [DIV_CNT_BITS-1:0] cnt_q;
	time_t                   quo_q;
	period_t                 rem_q;
	period_t                 dvs_q;

	logic [PERIOD_BITS:0] rem_sh;
	logic                 fits;
	logic [PERIOD_BITS:0] rem_nx;

	assign rem_sh = {rem_q, quo_q[TIME_BITS-1]};
	assign fits   = (rem_sh >= {1'b0, dvs_q});
	assign rem_nx = fits ? (rem_sh - {1'b0, dvs_q}) : rem_sh;

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_BITS'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[TIME_BITS-2:0], fits};
			rem_q <= rem_nx[PERIOD_BITS-1:0];
		end
	end

endmodule

// ===== rtl/core/ftfp_back.sv =====
// Back end: pacer state, deadline and counter updates, alpha and the result register.
module ftfp_back import ftfp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cfg_valid,
	input  period_t  cfg_data,
	input  q_stat_t  q_stat,
	input  cmd_t     pop_data,
	output logic     pop,
	output div_req_t div_req,
	input  div_rsp_t div_rsp,
	output logic     out_valid,
	input  logic     out_ready,
	output logic     sim_due,
	output logic     present_due,
	output alpha_t   alpha_q16,
	output time_t    next_deadline,
	output cnt_t     sim_frames,
	output cnt_t     present_count,
	output cnt_t     missed_count
);

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_EXEC  = 9'b000000010,
		ST_PDIV  = 9'b000000100,
		ST_PBASE = 9'b000001000,
		ST_PNEXT = 9'b000010000,
		ST_EVAL  = 9'b000100000,
		ST_ALPHA = 9'b001000000,
		ST_ADIV  = 9'b010000000,
		ST_OUT   = 9'b100000000
	} state_t;

	state_t  state_q;
	period_t period_q;
	time_t   sim_dl_q;
	time_t   pres_dl_q;
	cnt_t    sim_cnt_q;
	cnt_t    pres_cnt_q;
	cnt_t    missed_cnt_q;
	logic    out_valid_q;

	cmd_t    cmd_q;
	logic    late_q;
	time_t   base_q;
	time_t   diff_q;
	logic    res_sim_due_q;
	logic    res_pres_due_q;
	time_t   res_next_q;
	alpha_t  alpha_q;
	logic [ALPHA_X_BITS-1:0] alpha_x_q;

	logic    out_sim_due_q;
	logic    out_pres_due_q;
	alpha_t  out_alpha_q;
	time_t   out_next_q;
	cnt_t    out_sim_cnt_q;
	cnt_t    out_pres_cnt_q;
	cnt_t    out_missed_q;

	period_t period_eff;
	logic    late;
	time_t   overdue;
	logic    diff_big;
	logic [PROD_BITS-1:0] alpha_prod;
	logic    out_load;

	function automatic time_t add_sat_time(input time_t a, input time_t b);
		logic [TIME_BITS:0] sum;
		sum = {1'b0, a} + {1'b0, b};
		return sum[TIME_BITS] ? TIME_MAX : sum[TIME_BITS-1:0];
	endfunction

	function automatic cnt_t add_sat_cnt(input cnt_t a, input time_t b);
		logic [TIME_BITS:0] sum;
		sum = (TIME_BITS + 1)'(a) + {1'b0, b};
		return (sum > (TIME_BITS + 1)'(CNT_MAX)) ? CNT_MAX : sum[CNT_BITS-1:0];
	endfunction

	function automatic cnt_t inc_sat_cnt(input cnt_t a);
		return (a == CNT_MAX) ? CNT_MAX : a + 1'b1;
	endfunction

	assign period_eff = (period_q == '0) ? PERIOD_ONE : period_q;
	assign late       = (cmd_q.now > pres_dl_q);
	assign overdue    = late ? (cmd_q.now - pres_dl_q) : '0;
	assign diff_big   = (diff_q >= time_t'(SIM_PERIOD_TICKS));
	assign alpha_prod = PROD_BITS'(alpha_x_q) * PROD_BITS'(ALPHA_RECIP);
	assign out_load   = (state_q == ST_OUT) && (!out_valid_q || out_ready);
	assign pop        = (state_q == ST_IDLE) && !q_stat.empty;

	always_comb begin
		div_req.start    = (state_q == ST_EXEC) && (cmd_q.kind == CMD_PRESENT_DONE);
		div_req.dividend = overdue;
		div_req.divisor  = period_eff;
	end

	// Control and architectural state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			period_q     <= PRESENT_PERIOD_RESET;
			sim_dl_q     <= '0;
			pres_dl_q    <= '0;
			sim_cnt_q    <= '0;
			pres_cnt_q   <= '0;
			missed_cnt_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid) begin
				period_q <= cfg_data;
			end
			if (out_ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (!q_stat.empty) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					unique case (cmd_q.kind)
						CMD_RESTART: begin
							sim_dl_q     <= cmd_q.now;
							pres_dl_q    <= cmd_q.now;
							sim_cnt_q    <= '0;
							pres_cnt_q   <= '0;
							missed_cnt_q <= '0;
							state_q      <= ST_EVAL;
						end
						CMD_OBSERVE: begin
							state_q <= ST_EVAL;
						end
						CMD_SIM_DONE: begin
							sim_dl_q  <= add_sat_time(sim_dl_q, time_t'(SIM_PERIOD_TICKS));
							sim_cnt_q <= inc_sat_cnt(sim_cnt_q);
							state_q   <= ST_EVAL;
						end
						CMD_PRESENT_DONE: begin
							state_q <= ST_PDIV;
						end
						default: begin
							state_q <= ST_EVAL;
						end
					endcase
				end
				ST_PDIV: begin
					if (div_rsp.done) begin
						missed_cnt_q <= add_sat_cnt(missed_cnt_q, div_rsp.quotient);
						state_q      <= ST_PBASE;
					end
				end
				ST_PBASE: begin
					state_q <= ST_PNEXT;
				end
				ST_PNEXT: begin
					pres_dl_q  <= add_sat_time(base_q, time_t'(period_eff));
					pres_cnt_q <= inc_sat_cnt(pres_cnt_q);
					state_q    <= ST_EVAL;
				end
				ST_EVAL: begin
					state_q <= ST_ALPHA;
				end
				ST_ALPHA: begin
					state_q <= (res_sim_due_q || diff_big) ? ST_OUT : ST_ADIV;
				end
				ST_ADIV: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_load) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Working registers and the result register.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (!q_stat.empty) begin
					cmd_q <= pop_data;
				end
			end
			ST_EXEC: begin
				late_q <= late;
			end
			ST_PBASE: begin
				base_q <= late_q ? (cmd_q.now - time_t'(div_rsp.remainder)) : pres_dl_q;
			end
			ST_EVAL: begin
				res_sim_due_q  <= (cmd_q.now >= sim_dl_q);
				res_pres_due_q <= (cmd_q.now >= pres_dl_q);
				res_next_q     <= (sim_dl_q < pres_dl_q) ? sim_dl_q : pres_dl_q;
				diff_q         <= sim_dl_q - cmd_q.now;
			end
			ST_ALPHA: begin
				alpha_q   <= res_sim_due_q ? ALPHA_ONE : '0;
				alpha_x_q <= ALPHA_X_BITS'(SIM_PERIOD_TICKS - diff_q[PERIOD_BITS-1:0]);
			end
			ST_ADIV: begin
				alpha_q <= alpha_prod[RECIP_SHIFT +: ALPHA_BITS];
			end
			ST_OUT: begin
				if (out_load) begin
					out_sim_due_q  <= res_sim_due_q;
					out_pres_due_q <= res_pres_due_q;
					out_alpha_q    <= alpha_q;
					out_next_q     <= res_next_q;
					out_sim_cnt_q  <= sim_cnt_q;
					out_pres_cnt_q <= pres_cnt_q;
					out_missed_q   <= missed_cnt_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid     = out_valid_q;
	assign sim_due       = out_sim_due_q;
	assign present_due   = out_pres_due_q;
	assign alpha_q16     = out_alpha_q;
	assign next_deadline = out_next_q;
	assign sim_frames    = out_sim_cnt_q;
	assign present_count = out_pres_cnt_q;
	assign missed_count  = out_missed_q;

endmodule

// ===== rtl/core/fixed_timestep_frame_pacer.sv =====
// Top level of the fixed-timestep frame pacer: front end, command queue, back end, divider.
//
// Channel  Direction  Handshake              Payload
// input    in         in_valid / in_ready    mode, now
// result   out        out_valid / out_ready  sim_due, present_due, alpha_q16, next_deadline,
//                                            sim_frames, present_count, missed_count
// config   in         cfg_valid / cfg_ready  present_period_ticks
//
// Observe, restart and simulation done pass through the execute, evaluate and alpha states
// to the output state when the simulation deadline is already due or a period or more away,
// and through the reciprocal-multiply alpha state as well otherwise. Presentation done first
// waits on the 48-step radix-2 divider for the overdue periods, then forms the base and the
// next deadline. The front end takes a transaction whenever the two-entry queue has room, and
// the back end keeps working while a finished result waits in the output register, up to its
// output state. Reset is asynchronous and needs no clearing pass; config writes are always accepted.
module fixed_timestep_frame_pacer import ftfp_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  period_t              present_period_ticks,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [MODE_BITS-1:0] mode,
	input  time_t                now,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 sim_due,
	output logic                 present_due,
	output alpha_t               alpha_q16,
	output time_t                next_deadline,
	output cnt_t                 sim_frames,
	output cnt_t                 present_count,
	output cnt_t                 missed_count
);

	q_stat_t  q_stat;
	logic     push;
	cmd_t     push_data;
	logic     pop;
	cmd_t     pop_data;
	div_req_t div_req;
	div_rsp_t div_rsp;

	// The configuration register is a plain flop in the back end, so a write never stalls.
	assign cfg_ready = 1'b1;

	// The front end only does the handshake and decodes the mode; all time-dependent work is in the back end.
	ftfp_front u_front (
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.now       (now),
		.q_stat    (q_stat),
		.push      (push),
		.push_data (push_data)
	);

	ftfp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.stat      (q_stat)
	);

	// The divider counts the whole presentation periods that are overdue.
	ftfp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	ftfp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_data      (present_period_ticks),
		.q_stat        (q_stat),
		.pop_data      (pop_data),
		.pop           (pop),
		.div_req       (div_req),
		.div_rsp       (div_rsp),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.sim_due       (sim_due),
		.present_due   (present_due),
		.alpha_q16     (alpha_q16),
		.next_deadline (next_deadline),
		.sim_frames    (sim_frames),
		.present_count (present_count),
		.missed_count  (missed_count)
	);

endmodule

// ===== rtl/core/ftfp_checker.sv =====
// Port-level checks on the frame pacer result channel, bound to the top level.
module ftfp_checker import ftfp_pkg::*; (
	input logic   clk,
	input logic   arst_n,
	input logic   out_valid,
	input logic   out_ready,
	input logic   sim_due,
	input logic   present_due,
	input alpha_t alpha_q16,
	input time_t  next_deadline,
	input cnt_t   sim_frames,
	input cnt_t   present_count,
	input cnt_t   missed_count
);

	// A stalled result stays offered and unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sim_due) && $stable(present_due)
			&& $stable(alpha_q16) && $stable(next_deadline) && $stable(sim_frames)
			&& $stable(present_count) && $stable(missed_count))
		else $error("result changed while stalled");

	// The interpolation fraction never exceeds one.
	a_alpha_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> alpha_q16 <= ALPHA_ONE)
		else $error("alpha above one");

	// A full alpha appears exactly when the simulation step is due.
	a_alpha_due: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (sim_due == (alpha_q16 == ALPHA_ONE)))
		else $error("alpha disagrees with sim_due");

endmodule

bind fixed_timestep_frame_pacer ftfp_checker u_ftfp_checker (.*);
